// ===== hdl/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg: shared types, constants and the sine generator function
// Register map, reset values and operand widths of the falling-pitch synth.
// ----------------------------------------------------------------------------
package fps_pkg;

	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int INDEX_BITS_DEF      = 16;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 37;
	localparam int MUL_B_W = 19;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// |product| / 2^32 at or above this saturates after the divide by 7
	localparam logic [23:0] SAT_LIMIT = 24'd229376;
	// floor(m * RECIP_SEVEN / 2^RECIP_SHIFT) == floor(m / 7) for m < 349525
	localparam logic [36:0] RECIP_SEVEN = 37'd299594;
	localparam int          RECIP_SHIFT = 21;

	localparam logic [15:0] RST_SAMPLE_COUNT     = 16'd8000;
	localparam logic [30:0] RST_START_STEP       = 31'd139586437;
	localparam logic [30:0] RST_DROP_STEP        = 31'd51002737;
	localparam logic [30:0] RST_VIBRATO_STEP     = 31'd1610613;
	localparam logic [15:0] RST_VIBRATO_DEPTH    = 16'd1966;
	localparam logic [15:0] RST_ATTACK_FRACTION  = 16'd3932;
	localparam logic [15:0] RST_RELEASE_FRACTION = 16'd19661;
	localparam logic [15:0] RST_OUTPUT_GAIN      = 16'd45875;

	typedef enum logic [2:0] {
		REG_SAMPLE_COUNT,
		REG_START_STEP,
		REG_DROP_STEP,
		REG_VIBRATO_STEP,
		REG_VIBRATO_DEPTH,
		REG_ATTACK_FRACTION,
		REG_RELEASE_FRACTION,
		REG_OUTPUT_GAIN
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] sample_count;
		logic [30:0] start_step;
		logic [30:0] drop_step;
		logic [30:0] vibrato_step;
		logic [15:0] vibrato_depth;
		logic [15:0] attack_fraction;
		logic [15:0] release_fraction;
		logic [15:0] output_gain;
	} cfg_t;

	// 32767 * sin(pi/2 * r / quarter), ninth-order odd polynomial in Q30
	function automatic logic [15:0] quarter_sine(input int unsigned r, input int unsigned tb);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned p;
		longint unsigned v;
		x  = longint'(r) << (32 - tb);
		x2 = (x * x) >> 30;
		p  = 64'd172272;
		p  = 64'd5026995    - ((x2 * p) >> 30);
		p  = 64'd85569306   - ((x2 * p) >> 30);
		p  = 64'd693598669  - ((x2 * p) >> 30);
		p  = 64'd1686629713 - ((x2 * p) >> 30);
		v  = (x * p) >> 30;
		v  = (v * 64'd32767 + 64'd536870912) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

endpackage

// ===== hdl/fps_regs.sv =====
// ----------------------------------------------------------------------------
// fps_regs: configuration register file
// APB-style write/read port holding the eight synth settings.
// ----------------------------------------------------------------------------
module fps_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [fps_pkg::ADDR_W-1:0] paddr,
	input  logic [fps_pkg::DATA_W-1:0] pwdata,
	output logic [fps_pkg::DATA_W-1:0] prdata,
	output logic                      pready,
	output fps_pkg::cfg_t             cfg
);

	fps_pkg::cfg_t    cfg_q;
	fps_pkg::reg_idx_t idx;
	logic             wr_en;

	assign pready = 1'b1;
	assign idx    = fps_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_count     <= fps_pkg::RST_SAMPLE_COUNT;
			cfg_q.start_step       <= fps_pkg::RST_START_STEP;
			cfg_q.drop_step        <= fps_pkg::RST_DROP_STEP;
			cfg_q.vibrato_step     <= fps_pkg::RST_VIBRATO_STEP;
			cfg_q.vibrato_depth    <= fps_pkg::RST_VIBRATO_DEPTH;
			cfg_q.attack_fraction  <= fps_pkg::RST_ATTACK_FRACTION;
			cfg_q.release_fraction <= fps_pkg::RST_RELEASE_FRACTION;
			cfg_q.output_gain      <= fps_pkg::RST_OUTPUT_GAIN;
		end else if (wr_en) begin
			unique case (idx)
				fps_pkg::REG_SAMPLE_COUNT:     cfg_q.sample_count     <= pwdata[15:0];
				fps_pkg::REG_START_STEP:       cfg_q.start_step       <= pwdata[30:0];
				fps_pkg::REG_DROP_STEP:        cfg_q.drop_step        <= pwdata[30:0];
				fps_pkg::REG_VIBRATO_STEP:     cfg_q.vibrato_step     <= pwdata[30:0];
				fps_pkg::REG_VIBRATO_DEPTH:    cfg_q.vibrato_depth    <= pwdata[15:0];
				fps_pkg::REG_ATTACK_FRACTION:  cfg_q.attack_fraction  <= pwdata[15:0];
				fps_pkg::REG_RELEASE_FRACTION: cfg_q.release_fraction <= pwdata[15:0];
				fps_pkg::REG_OUTPUT_GAIN:      cfg_q.output_gain      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			fps_pkg::REG_SAMPLE_COUNT:     prdata = {16'd0, cfg_q.sample_count};
			fps_pkg::REG_START_STEP:       prdata = {1'b0, cfg_q.start_step};
			fps_pkg::REG_DROP_STEP:        prdata = {1'b0, cfg_q.drop_step};
			fps_pkg::REG_VIBRATO_STEP:     prdata = {1'b0, cfg_q.vibrato_step};
			fps_pkg::REG_VIBRATO_DEPTH:    prdata = {16'd0, cfg_q.vibrato_depth};
			fps_pkg::REG_ATTACK_FRACTION:  prdata = {16'd0, cfg_q.attack_fraction};
			fps_pkg::REG_RELEASE_FRACTION: prdata = {16'd0, cfg_q.release_fraction};
			fps_pkg::REG_OUTPUT_GAIN:      prdata = {16'd0, cfg_q.output_gain};
			default:                       prdata = '0;
		endcase
	end

endmodule

// ===== hdl/fps_sine.sv =====
// ----------------------------------------------------------------------------
// fps_sine: sine lookup
// Quarter-wave constant table, mirrored to the full wave, Q1.15 out.
// ----------------------------------------------------------------------------
module fps_sine #(
	parameter int SINE_TABLE_BITS = fps_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic [31:0]        phase,
	output logic signed [15:0] value
);

	localparam int QB      = SINE_TABLE_BITS - 2;
	localparam int QUARTER = 1 << QB;

	logic [15:0]                qtab [QUARTER+1];
	logic [SINE_TABLE_BITS-1:0] k;
	logic [QB:0]                addr;
	logic [15:0]                mag;

	for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
		assign qtab[g] = fps_pkg::quarter_sine(g, SINE_TABLE_BITS);
	end

	assign k = phase[31 -: SINE_TABLE_BITS];

	// odd quarters run backward; the top entry holds the peak
	assign addr  = k[QB] ? ((QB+1)'(QUARTER) - {1'b0, k[QB-1:0]}) : {1'b0, k[QB-1:0]};
	assign mag   = qtab[addr];
	assign value = k[QB+1] ? -$signed(mag) : $signed(mag);

endmodule

// ===== hdl/fps_mul.sv =====
// ----------------------------------------------------------------------------
// fps_mul: shared signed multiplier
// One registered signed product per cycle for the sequencer.
// ----------------------------------------------------------------------------
module fps_mul (
	input  logic                               clk,
	input  logic signed [fps_pkg::MUL_A_W-1:0] a,
	input  logic signed [fps_pkg::MUL_B_W-1:0] b,
	output logic signed [fps_pkg::MUL_P_W-1:0] p
);

	logic signed [fps_pkg::MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ===== hdl/fps_div.sv =====
// ----------------------------------------------------------------------------
// fps_div: shared serial divider
// Restoring divide, one quotient bit per cycle; dividend < divisor * 2^16.
// ----------------------------------------------------------------------------
module fps_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic [15:0] quotient
);

	logic [15:0] rem_q;
	logic [15:0] dq_q;
	logic [15:0] dv_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [16:0] trial;
	logic        fits;

	assign trial    = {rem_q, dq_q[15]};
	assign fits     = trial >= {1'b0, dv_q};
	assign done     = done_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 5'd16;
			end else if (cnt_q != 5'd0) begin
				cnt_q  <= cnt_q - 5'd1;
				done_q <= (cnt_q == 5'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[31:16];
			dq_q  <= dividend[15:0];
			dv_q  <= divisor;
		end else if (cnt_q != 5'd0) begin
			rem_q <= fits ? 16'(trial - {1'b0, dv_q}) : trial[15:0];
			dq_q  <= {dq_q[14:0], fits};
		end
	end

endmodule

// ===== hdl/falling_pitch_voice_synth_top.sv =====
// ----------------------------------------------------------------------------
// falling_pitch_voice_synth_top: falling-pitch sine voice generator
// One PCM sample per item: vibrato, three harmonics, envelope and gain.
// ----------------------------------------------------------------------------
// One item at a time: in_stall is high from accept until the result is
// registered; an item after the sound has finished skips to output. Up to two
// shared serial divider passes (progress, envelope in attack or release) plus
// the shared multiplier steps (divide by 7 included) set the rate.
// Reset: sample index to zero, registers to their defaults, no result held.
module falling_pitch_voice_synth_top #(
	parameter int SINE_TABLE_BITS = fps_pkg::SINE_TABLE_BITS_DEF,
	parameter int INDEX_BITS      = fps_pkg::INDEX_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       restart,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [15:0]         sample,
	output logic                       last,
	output logic                       done_res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fps_pkg::ADDR_W-1:0] paddr,
	input  logic [fps_pkg::DATA_W-1:0] pwdata,
	output logic [fps_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int CW = (INDEX_BITS > 16) ? INDEX_BITS : 16;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIVP, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
		ST_S2, ST_S3, ST_ENV, ST_DIVE, ST_M8, ST_M9, ST_M10, ST_DIVS, ST_OUT
	} state_t;

	fps_pkg::cfg_t cfg;
	state_t        state_q;

	logic [INDEX_BITS-1:0] idx_q;
	logic [INDEX_BITS-1:0] idx_eff;
	logic [15:0]           i_q;
	logic [15:0]           prog_q;
	logic signed [18:0]    vib_q;
	logic signed [31:0]    base_q;
	logic [31:0]           ph_q;
	logic signed [18:0]    acc_q;
	logic [16:0]           env_q;
	logic                  neg_q;
	logic signed [15:0]    res_q;
	logic                  last_q;
	logic                  fin_q;

	logic                  out_valid_q;
	logic signed [15:0]    sample_q;
	logic                  last_out_q;
	logic                  done_out_q;

	logic                  accept;
	logic                  finished;

	logic signed [fps_pkg::MUL_A_W-1:0] mul_a;
	logic signed [fps_pkg::MUL_B_W-1:0] mul_b;
	logic signed [fps_pkg::MUL_P_W-1:0] mul_p;
	logic [fps_pkg::MUL_P_W-1:0]        abs_p;
	logic [23:0]                        mag;

	logic [31:0]        sin_phase;
	logic signed [15:0] sin_val;

	logic        div_start;
	logic [31:0] div_dividend;
	logic [15:0] div_divisor;
	logic        div_done;
	logic [15:0] div_q;

	logic        in_attack;
	logic        in_release;

	fps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fps_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
		.phase (sin_phase),
		.value (sin_val)
	);

	fps_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	fps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_q)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid & ~in_stall;
	assign idx_eff   = restart ? '0 : idx_q;
	assign finished  = CW'(idx_eff) >= CW'(cfg.sample_count);

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign last      = last_out_q;
	assign done_res  = done_out_q;

	assign in_attack  = prog_q < cfg.attack_fraction;
	assign in_release = ({1'b0, prog_q} + {1'b0, cfg.release_fraction}) > 17'h10000;

	assign abs_p = mul_p[fps_pkg::MUL_P_W-1] ? 56'(-mul_p) : 56'(mul_p);
	assign mag   = abs_p[55:32];

	always_comb begin
		unique case (state_q)
			ST_S2:   sin_phase = {ph_q[30:0], 1'b0};
			ST_S3:   sin_phase = ph_q + {ph_q[30:0], 1'b0};
			default: sin_phase = mul_p[31:0];
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_M1: begin
				mul_a = {6'd0, cfg.vibrato_step};
				mul_b = {3'd0, i_q};
			end
			ST_M2: begin
				mul_a = {{21{sin_val[15]}}, sin_val};
				mul_b = {3'd0, cfg.vibrato_depth};
			end
			ST_M3: begin
				mul_a = {6'd0, cfg.drop_step};
				mul_b = {3'd0, prog_q};
			end
			ST_M5: begin
				mul_a = {{5{base_q[31]}}, base_q};
				mul_b = vib_q;
			end
			ST_M6: begin
				mul_a = {5'd0, mul_p[47:16]};
				mul_b = {3'd0, i_q};
			end
			ST_M8: begin
				mul_a = {{18{acc_q[18]}}, acc_q};
				mul_b = {2'd0, env_q};
			end
			ST_M9: begin
				mul_a = mul_p[36:0];
				mul_b = {3'd0, cfg.output_gain};
			end
			ST_M10: begin
				// divide by 7 as a reciprocal multiply
				mul_a = fps_pkg::RECIP_SEVEN;
				mul_b = {1'b0, mag[17:0]};
			end
			default: ;
		endcase
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			ST_IDLE: begin
				div_start    = accept & ~finished;
				div_dividend = {16'(idx_eff), 16'd0};
				div_divisor  = cfg.sample_count;
			end
			ST_ENV: begin
				if (in_attack) begin
					div_start    = 1'b1;
					div_dividend = {prog_q, 16'd0};
					div_divisor  = cfg.attack_fraction;
				end else if (in_release) begin
					div_start    = 1'b1;
					div_dividend = {16'(17'h10000 - {1'b0, prog_q}), 16'd0};
					div_divisor  = cfg.release_fraction;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q  <= idx_eff;
						i_q    <= 16'(idx_eff);
						last_q <= ({1'b0, 16'(idx_eff)} + 17'd1) == {1'b0, cfg.sample_count};
						fin_q  <= finished;
						res_q  <= '0;
						state_q <= finished ? ST_OUT : ST_DIVP;
					end
				end
				ST_DIVP: begin
					if (div_done) begin
						prog_q  <= div_q;
						state_q <= ST_M1;
					end
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: begin
					vib_q   <= 19'sd65536 + $signed(mul_p[33:15]);
					state_q <= ST_M4;
				end
				ST_M4: begin
					base_q  <= $signed({1'b0, cfg.start_step}) - $signed({1'b0, mul_p[46:16]});
					state_q <= ST_M5;
				end
				ST_M5: state_q <= ST_M6;
				ST_M6: state_q <= ST_M7;
				ST_M7: begin
					ph_q    <= mul_p[31:0];
					acc_q   <= {sin_val[15], sin_val, 2'b00};
					state_q <= ST_S2;
				end
				ST_S2: begin
					acc_q   <= acc_q + {{2{sin_val[15]}}, sin_val, 1'b0};
					state_q <= ST_S3;
				end
				ST_S3: begin
					acc_q   <= acc_q + {{3{sin_val[15]}}, sin_val};
					state_q <= ST_ENV;
				end
				ST_ENV: begin
					if (in_attack || in_release) begin
						state_q <= ST_DIVE;
					end else begin
						env_q   <= 17'h10000;
						state_q <= ST_M8;
					end
				end
				ST_DIVE: begin
					if (div_done) begin
						env_q   <= {1'b0, div_q};
						state_q <= ST_M8;
					end
				end
				ST_M8: state_q <= ST_M9;
				ST_M9: state_q <= ST_M10;
				ST_M10: begin
					neg_q <= mul_p[fps_pkg::MUL_P_W-1];
					if (mag >= fps_pkg::SAT_LIMIT) begin
						res_q   <= mul_p[fps_pkg::MUL_P_W-1] ? -16'sd32768 : 16'sd32767;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					res_q   <= neg_q ? -$signed(mul_p[fps_pkg::RECIP_SHIFT +: 16])
					                 : $signed(mul_p[fps_pkg::RECIP_SHIFT +: 16]);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						sample_q    <= res_q;
						last_out_q  <= ~fin_q & last_q;
						done_out_q  <= fin_q;
						if (!fin_q) begin
							idx_q <= INDEX_BITS'(idx_q + 1'b1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
